FILE: design/u8dec_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8dec_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// Continuation count announced by a lead byte
	localparam logic [1:0] EXTRA_NONE  = 2'd0;
	localparam logic [1:0] EXTRA_ONE   = 2'd1;
	localparam logic [1:0] EXTRA_TWO   = 2'd2;
	localparam logic [1:0] EXTRA_THREE = 2'd3;

	// Sequence state carried from one byte to the next
	typedef struct packed {
		logic [CP_W-1:0] acc;
		logic [1:0]      remaining;
		logic            bad;
	} dec_state_t;

	// Result of one byte step
	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] cp;
		logic            last;
	} dec_result_t;

	localparam dec_state_t STATE_CLEAR = '{acc: '0, remaining: EXTRA_NONE, bad: 1'b0};

endpackage

FILE: design/u8dec_step.sv
// Combinational decode of one byte against the current sequence state.
module u8dec_step (
	input  logic [7:0]             byte_in,
	input  logic                   end_of_string,
	input  u8dec_pkg::dec_state_t  cur,
	output u8dec_pkg::dec_state_t  nxt,
	output u8dec_pkg::dec_result_t res
);
	import u8dec_pkg::*;

	logic            is_cont;
	logic            bad_n;
	logic [CP_W-1:0] acc_n;
	logic [1:0]      rem_n;

	// Shift in six payload bits on a well-formed continuation, else mark bad
	assign is_cont = (byte_in[7:6] == 2'b10);
	assign bad_n   = cur.bad | ~is_cont;
	assign acc_n   = is_cont ? {cur.acc[CP_W-7:0], byte_in[5:0]} : cur.acc;
	assign rem_n   = cur.remaining - 2'd1;

	always_comb begin
		nxt = cur;
		res = '{emit: 1'b0, cp: REPLACEMENT_CP, last: end_of_string};
		if (cur.remaining == EXTRA_NONE) begin
			// Expecting a lead byte
			priority if (byte_in[7] == 1'b0) begin
				res.emit = 1'b1;
				res.cp   = {{(CP_W-8){1'b0}}, byte_in};
			end else if (byte_in[7:5] == 3'b110) begin
				nxt = '{acc: {{(CP_W-5){1'b0}}, byte_in[4:0]}, remaining: EXTRA_ONE,
					bad: 1'b0};
			end else if (byte_in[7:4] == 4'b1110) begin
				nxt = '{acc: {{(CP_W-4){1'b0}}, byte_in[3:0]}, remaining: EXTRA_TWO,
					bad: 1'b0};
			end else if (byte_in[7:3] == 5'b11110) begin
				nxt = '{acc: {{(CP_W-3){1'b0}}, byte_in[2:0]}, remaining: EXTRA_THREE,
					bad: 1'b0};
			end else begin
				// Invalid lead: replace at once
				res.emit = 1'b1;
			end
			// Multi-byte lead on the final byte: truncated string
			if (byte_in[7:6] == 2'b11 && byte_in[7:3] != 5'b11111 && end_of_string) begin
				nxt      = STATE_CLEAR;
				res.emit = 1'b1;
				res.last = 1'b1;
			end
		end else begin
			// Expecting a continuation byte
			priority if (rem_n == EXTRA_NONE) begin
				nxt      = STATE_CLEAR;
				res.emit = 1'b1;
				res.cp   = bad_n ? REPLACEMENT_CP : acc_n;
			end else if (end_of_string) begin
				nxt      = STATE_CLEAR;
				res.emit = 1'b1;
				res.last = 1'b1;
			end else begin
				nxt = '{acc: acc_n, remaining: rem_n, bad: bad_n};
			end
		end
	end

endmodule

FILE: design/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte in per beat, zero or one code point out.
// A result beat is registered and valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the single output register sets this rate,
// and a new byte is taken whenever that register is empty or being drained.
// Reset clears the sequence state and the output valid flag.
module utf8_stream_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 byte_in,
	input  logic                       end_of_string,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [u8dec_pkg::CP_W-1:0] code_point,
	output logic                       last_point
);
	import u8dec_pkg::*;

	dec_state_t      state_q;
	dec_state_t      state_nxt;
	dec_result_t     res;
	logic            out_valid_q;
	logic [CP_W-1:0] cp_q;
	logic            last_q;
	logic            in_fire;

	assign in_ready = ~out_valid_q | out_ready;
	assign in_fire  = in_valid & in_ready;

	u8dec_step u_step (
		.byte_in       (byte_in),
		.end_of_string (end_of_string),
		.cur           (state_q),
		.nxt           (state_nxt),
		.res           (res)
	);

	// Advance the sequence state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result beat until taken; refill on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res.emit) begin
			cp_q   <= res.cp;
			last_q <= res.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign last_point = last_q;

endmodule

FILE: design/u8dec_chk.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8dec_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  byte_in,
	input logic        end_of_string,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] code_point,
	input logic        last_point
);

	// A stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(last_point))
		else $error("result beat changed while stalled");

	// A stalled output blocks new bytes
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte accepted while result beat stalled");

	// The final byte of a string always closes it with a last code point
	a_eos_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_string |=> out_valid && last_point)
		else $error("string end gave no last code point");

	// A result beat only appears after an accepted byte
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an accepted byte");

endmodule

bind utf8_stream_decoder u8dec_chk u_chk (.*);
